// File: rtl/core/lpht_pkg.sv
// Package for the linear-probing hash table: field widths, operation and status codes,
// the input, result and table-entry structs, and the controller/datapath interface structs.
// Has no dependencies; the other rtl/core files but lpht_ram refer to it by scoped names.
package lpht_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W    = 31;
    localparam int PAY_W    = 31;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int ENTRY_W  = 1 + KEY_W + PAY_W;

    // Step counter of the two-stage remainder unit: multiply, then correct the low bits.
    localparam int HCNT_W = 1;
    localparam logic [HCNT_W-1:0] HCNT_INIT = 1'b1;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [PAY_W-1:0]    pay_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    // Operation codes.
    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_DELETE = 2'd1;
    localparam op_t OP_SEARCH = 2'd2;

    // Result status codes.
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    typedef struct packed {
        op_t  opcode;
        key_t key;
        pay_t payload;
    } lpht_in_t;

    typedef struct packed {
        status_t status;
        slot_t   slot;
        pay_t    found_payload;
    } lpht_out_t;

    // One table slot as it is held in memory.
    typedef struct packed {
        logic valid;
        key_t key;
        pay_t payload;
    } lpht_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic hash_step;
        logic scan_start;
        logic scan_step;
        logic capture;
        logic clear_step;
        logic out_load;
    } lpht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_insert;
        logic hash_last;
        logic op_bad;
        logic scan_hit;
        logic scan_end;
        logic clear_last;
        logic out_free;
    } lpht_sts_t;

endpackage

// File: rtl/core/lpht_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Has no dependencies.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/lpht_ctrl.sv
// Controller state machine of the hash table: sequences clearing, hashing, slot scanning
// and result hand-off. Depends on lpht_pkg for the command and status structs.
module lpht_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output lpht_pkg::lpht_cmd_t  cmd,
    input  lpht_pkg::lpht_sts_t  sts
);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        HASH,
        PREP,
        SCAN,
        FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    // Next state and the commands issued in each state.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_insert ? HASH : PREP;
                end
            end
            HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last) begin
                    state_next = PREP;
                end
            end
            PREP: begin
                cmd.scan_start = 1'b1;
                if (sts.op_bad) begin
                    cmd.capture = 1'b1;
                    state_next  = FINISH;
                end else begin
                    state_next = SCAN;
                end
            end
            SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit || sts.scan_end) begin
                    cmd.capture = 1'b1;
                    state_next  = FINISH;
                end
            end
            FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = CLEAR;
            end
        endcase
    end

    // State register and the registered ready output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// File: rtl/core/lpht_dp.sv
// Datapath of the hash table: item registers, reciprocal remainder unit, slot memory with its
// scan pipeline, result capture and the output register. Depends on lpht_pkg and lpht_ram.
module lpht_dp #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpht_pkg::lpht_cmd_t  cmd,
    output lpht_pkg::lpht_sts_t  sts,
    input  lpht_pkg::lpht_in_t   s_data,
    output lpht_pkg::lpht_out_t  m_data,
    output logic                 m_valid,
    input  logic                 m_ready
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_SIZE);

    // Scaled reciprocal of the table size; the shift makes the quotient exact for any key.
    localparam int PROD_W     = lpht_pkg::KEY_W + 32;
    localparam int HASH_SHIFT = lpht_pkg::KEY_W + IDX_W;
    localparam longint unsigned MAGIC_FULL =
        ((64'd1 << HASH_SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [31:0]      HASH_MAGIC = 32'(MAGIC_FULL);
    localparam logic [IDX_W-1:0] SIZE_LOW   = IDX_W'(TABLE_SIZE);

    // Item registers.
    lpht_pkg::op_t  op_reg;
    lpht_pkg::key_t key_reg;
    lpht_pkg::pay_t pay_reg;

    // Remainder unit.
    logic [PROD_W-1:0]           prod_reg;
    logic [IDX_W-1:0]            rem_reg;
    logic [lpht_pkg::HCNT_W-1:0] hcnt_reg;
    logic [IDX_W-1:0]            quo_low;
    logic [IDX_W-1:0]            rem_next;

    // Scan pipeline.
    logic [IDX_W-1:0] rd_addr_reg;
    logic [IDX_W-1:0] addr_inc;
    logic [CNT_W-1:0] issue_cnt_reg;
    logic             chk_valid_reg;
    logic [IDX_W-1:0] chk_addr_reg;
    logic             issue_more;

    // Memory ports.
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [lpht_pkg::ENTRY_W-1:0] ram_wdata;
    logic [lpht_pkg::ENTRY_W-1:0] ram_rdata;
    lpht_pkg::lpht_entry_t        rd_entry;
    lpht_pkg::lpht_entry_t        wr_entry;

    // Decode and result.
    logic                 op_insert;
    logic                 op_delete;
    logic                 op_search;
    logic                 op_bad;
    logic                 slot_hit;
    lpht_pkg::lpht_out_t  res_reg;
    lpht_pkg::lpht_out_t  res_next;
    lpht_pkg::lpht_out_t  out_reg;
    logic                 m_valid_reg;

    lpht_ram #(
        .WIDTH (lpht_pkg::ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Operation decode from the held item.
    assign op_insert = (op_reg == lpht_pkg::OP_INSERT);
    assign op_delete = (op_reg == lpht_pkg::OP_DELETE);
    assign op_search = (op_reg == lpht_pkg::OP_SEARCH);
    assign op_bad    = !(op_insert || op_delete || op_search);

    // The remainder is below the table size, so only the low bits of key - q * size matter.
    assign quo_low  = prod_reg[HASH_SHIFT +: IDX_W];
    assign rem_next = key_reg[IDX_W-1:0] - IDX_W'(quo_low * SIZE_LOW);

    // Item capture; the first hash step forms the product, the second the remainder.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_data.opcode;
            key_reg  <= s_data.key;
            pay_reg  <= s_data.payload;
            rem_reg  <= '0;
            hcnt_reg <= lpht_pkg::HCNT_INIT;
        end else if (cmd.hash_step) begin
            prod_reg <= PROD_W'(key_reg) * PROD_W'(HASH_MAGIC);
            rem_reg  <= rem_next;
            hcnt_reg <= hcnt_reg - 1'b1;
        end
    end

    // Slot address walk, wrapping past the last slot.
    assign addr_inc   = (rd_addr_reg == LAST_IDX) ? '0 : rd_addr_reg + 1'b1;
    assign issue_more = (issue_cnt_reg != CNT_FULL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg   <= '0;
            issue_cnt_reg <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            chk_valid_reg <= cmd.scan_step && issue_more;
            if (cmd.scan_start) begin
                rd_addr_reg   <= op_insert ? rem_reg : '0;
                issue_cnt_reg <= '0;
            end else if (cmd.clear_step) begin
                rd_addr_reg <= addr_inc;
            end else if (cmd.scan_step && issue_more) begin
                rd_addr_reg   <= addr_inc;
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
        end
    end

    // Address of the slot whose data arrives from memory in the next cycle.
    always_ff @(posedge aclk) begin
        if (cmd.scan_step && issue_more) begin
            chk_addr_reg <= rd_addr_reg;
        end
    end

    // Slot check: a free slot for insert, a valid matching key for delete and search.
    assign rd_entry = lpht_pkg::lpht_entry_t'(ram_rdata);
    assign slot_hit = chk_valid_reg && !op_bad &&
                      (op_insert ? !rd_entry.valid
                                 : (rd_entry.valid && (rd_entry.key == key_reg)));

    // Memory writes: the clearing pass after reset, an insert, or a delete.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = chk_addr_reg;
        wr_entry  = '0;
        if (cmd.clear_step) begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr_reg;
        end else if (cmd.capture && slot_hit && !op_search) begin
            ram_we           = 1'b1;
            wr_entry.valid   = op_insert;
            wr_entry.key     = op_insert ? key_reg : '0;
            wr_entry.payload = op_insert ? pay_reg : '0;
        end
    end

    assign ram_wdata = wr_entry;

    // Result of the finished operation.
    always_comb begin
        res_next               = '0;
        res_next.status        = lpht_pkg::ST_MISS;
        if (slot_hit) begin
            res_next.status        = lpht_pkg::ST_OK;
            res_next.slot          = lpht_pkg::slot_t'(chk_addr_reg);
            res_next.found_payload = op_search ? rd_entry.payload : '0;
        end else if (op_insert) begin
            res_next.status = lpht_pkg::ST_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_reg <= res_next;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    // Output valid flag: set on load, cleared once the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

    // Status to the controller.
    assign sts.in_insert  = (s_data.opcode == lpht_pkg::OP_INSERT);
    assign sts.hash_last  = (hcnt_reg == '0);
    assign sts.op_bad     = op_bad;
    assign sts.scan_hit   = slot_hit;
    assign sts.scan_end   = chk_valid_reg && !issue_more;
    assign sts.clear_last = (rd_addr_reg == LAST_IDX);
    assign sts.out_free   = !m_valid_reg || m_ready;

endmodule

// File: rtl/core/linear_probe_hash_table.sv
// Linear-probing hash table: TABLE_SIZE slots of key and payload with insert, delete and search.
// Instantiates lpht_ctrl and lpht_dp; types and codes come from lpht_pkg.
//
// Usage:
//   s_valid/s_ready/s_data carry one operation per transfer (opcode, key, payload).
//   m_valid/m_ready/m_data return exactly one result per operation (status, slot,
//   found_payload), in order.
//   Insert first reduces the key modulo TABLE_SIZE by a multiplication with a scaled
//   reciprocal and a correction of the low bits, then probes from the home slot
//   forward, one slot per cycle through the slot memory's registered read port.
//   Delete and search scan from slot 0.
//   Insert, delete and search examine 1 to TABLE_SIZE slots; an undefined opcode
//   skips the scan. s_ready rises at the same edge as m_valid, so one operation
//   is in work at a time.
//   After reset a clearing pass writes every slot empty, with s_ready low throughout.
//   The result waits in an output register; the block may take the next operation
//   while it waits, but holds that operation's result until the register is free.
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpht_pkg::lpht_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lpht_pkg::lpht_out_t  m_data
);

    lpht_pkg::lpht_cmd_t cmd;
    lpht_pkg::lpht_sts_t sts;

    // Sequencer.
    lpht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Slot memory, remainder unit and result registers.
    lpht_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule

// File: rtl/core/lpht_checker.sv
// Port-level checks for the hash table, attached to the top level by the bind below.
// Depends on lpht_pkg for the result struct and status codes.
module lpht_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lpht_pkg::lpht_out_t m_data
);

    // A pending result stays offered until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before transfer");

    // The clearing pass keeps the input closed straight after reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready)
        else $error("input ready during clearing pass");

    // One operation at a time: an accepted item closes the input in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in work");

    // Only legal status codes, and a failure reports slot and payload as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == lpht_pkg::ST_OK) ||
                    (m_data.status == lpht_pkg::ST_MISS) ||
                    (m_data.status == lpht_pkg::ST_FULL))
        else $error("illegal status code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != lpht_pkg::ST_OK) |->
            (m_data.slot == '0) && (m_data.found_payload == '0))
        else $error("failure result with nonzero slot or payload");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: verif/linear_probe_hash_table_test.sv
// Self-checking testbench for linear_probe_hash_table: directed table of operations, then
// random traffic of all four opcodes checked against a behavioural mirror of the table.
// Depends on lpht_pkg for the transfer structs and the operation and status codes.
module linear_probe_hash_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int TABLE_SIZE   = 16;
    localparam int RANDOM_OPS   = 1100;
    localparam int POOL_SIZE    = 20;
    localparam int HOLDOFF_AT   = 250;
    localparam int HOLDOFF_LEN  = 400;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 700;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_NS  = 4_000_000;
    localparam int MAX_REPORTS  = 10;

    // The fourth opcode value has no defined meaning.
    localparam op_t  OP_UNDEFINED = 2'd3;
    localparam key_t KEY_ALL      = '1;
    localparam pay_t PAY_ALL      = '1;

    typedef struct {
        lpht_in_t  item;
        bit        typed;
        lpht_out_t result;
    } stim_row_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    lpht_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    lpht_out_t m_data;

    // Mirror of the slot memory.
    bit   mirror_valid [TABLE_SIZE];
    key_t mirror_key   [TABLE_SIZE];
    pay_t mirror_payload [TABLE_SIZE];

    lpht_out_t pending_results [$];
    stim_row_t directed_rows [$];
    key_t      key_pool [POOL_SIZE];

    bit calm          = 1'b0;
    int error_count   = 0;
    int results_seen  = 0;
    int n_insert      = 0;
    int n_delete      = 0;
    int n_search      = 0;
    int n_undefined   = 0;
    int n_full        = 0;
    int n_miss        = 0;

    linear_probe_hash_table #(
        .TABLE_SIZE(TABLE_SIZE)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Guard against a hang anywhere in the run.
    initial begin
        #(WATCHDOG_NS);
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic lpht_in_t make_op(op_t opcode, key_t key, pay_t payload);
        lpht_in_t op_in;
        op_in.opcode  = opcode;
        op_in.key     = key;
        op_in.payload = payload;
        return op_in;
    endfunction

    function automatic lpht_out_t make_result(status_t status, slot_t slot, pay_t found);
        lpht_out_t res;
        res.status        = status;
        res.slot          = slot;
        res.found_payload = found;
        return res;
    endfunction

    // Applies one operation to the mirror and returns the result it must produce.
    function automatic lpht_out_t hash_table_outcome(lpht_in_t op_in);
        lpht_out_t res;
        int        pos;
        int        hit;
        bit        stored;
        res    = make_result(ST_MISS, '0, '0);
        hit    = -1;
        stored = 1'b0;
        case (op_in.opcode)
            OP_INSERT: begin
                // Probe forward from the home slot, wrapping, for the first free slot.
                res.status = ST_FULL;
                pos = int'(op_in.key % TABLE_SIZE);
                for (int n = 0; n < TABLE_SIZE; n++) begin
                    if (!stored && !mirror_valid[pos]) begin
                        mirror_valid[pos]   = 1'b1;
                        mirror_key[pos]     = op_in.key;
                        mirror_payload[pos] = op_in.payload;
                        res    = make_result(ST_OK, slot_t'(pos), '0);
                        stored = 1'b1;
                    end
                    pos = (pos + 1) % TABLE_SIZE;
                end
            end
            OP_DELETE, OP_SEARCH: begin
                // Scanning downwards leaves the lowest-index match in hit.
                for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
                    if (mirror_valid[i] && mirror_key[i] == op_in.key) hit = i;
                end
                if (hit >= 0) begin
                    if (op_in.opcode == OP_DELETE) begin
                        mirror_valid[hit] = 1'b0;
                        res = make_result(ST_OK, slot_t'(hit), '0);
                    end else begin
                        res = make_result(ST_OK, slot_t'(hit), mirror_payload[hit]);
                    end
                end
            end
            default: begin
                res = make_result(ST_MISS, '0, '0);
            end
        endcase
        return res;
    endfunction

    task automatic add_row(input lpht_in_t item, input bit typed, input lpht_out_t res);
        stim_row_t row;
        row.item   = item;
        row.typed  = typed;
        row.result = res;
        directed_rows.push_back(row);
    endtask

    // Offers one operation and records its expected result once the transfer happens.
    task automatic send_op(input lpht_in_t op_in, input bit typed, input lpht_out_t typed_res);
        lpht_out_t predicted;
        s_valid <= 1'b1;
        s_data  <= op_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = hash_table_outcome(op_in);
        pending_results.push_back(typed ? typed_res : predicted);
        case (op_in.opcode)
            OP_INSERT: n_insert++;
            OP_DELETE: n_delete++;
            OP_SEARCH: n_search++;
            default:   n_undefined++;
        endcase
        if (predicted.status == ST_FULL) n_full++;
        if (predicted.status == ST_MISS) n_miss++;
    endtask

    // Random gap on the sending side, skipped during the calm stretch.
    task automatic pause_sender();
        int gap;
        if (!calm && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stimulus: reset, directed table, then random traffic.
    initial begin
        lpht_in_t op_in;
        op_t      opcode;
        int       roll;
        bit       fill_phase;

        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = key_t'($urandom);
            // Half the pool shares a few home slots so that probe chains form.
            if (i < POOL_SIZE / 2) key_pool[i][3:0] = 4'($urandom_range(0, 3));
        end
        key_pool[0] = '0;
        key_pool[1] = KEY_ALL;

        // Directed rows; extremes and error codes carry their own expectation.
        add_row(make_op(OP_SEARCH, 31'd5, '0), 1'b1, make_result(ST_MISS, '0, '0));
        add_row(make_op(OP_UNDEFINED, KEY_ALL, PAY_ALL), 1'b1, make_result(ST_MISS, '0, '0));
        add_row(make_op(OP_INSERT, '0, '0), 1'b1, make_result(ST_OK, 4'd0, '0));
        add_row(make_op(OP_INSERT, KEY_ALL, PAY_ALL), 1'b1, make_result(ST_OK, 4'd15, '0));
        add_row(make_op(OP_INSERT, 31'd16, 31'h2AAA_AAAA), 1'b0, '0);
        add_row(make_op(OP_INSERT, 31'd31, 31'h5555_5555), 1'b0, '0);
        add_row(make_op(OP_INSERT, '0, 31'h0123_4567), 1'b0, '0);
        add_row(make_op(OP_SEARCH, '0, PAY_ALL), 1'b0, '0);
        add_row(make_op(OP_SEARCH, KEY_ALL, '0), 1'b1, make_result(ST_OK, 4'd15, PAY_ALL));
        add_row(make_op(OP_DELETE, '0, '0), 1'b0, '0);
        add_row(make_op(OP_SEARCH, '0, '0), 1'b0, '0);
        for (int i = 0; i < 12; i++) begin
            add_row(make_op(OP_INSERT, 31'd5, pay_t'($urandom)), 1'b0, '0);
        end
        add_row(make_op(OP_INSERT, 31'd7, 31'h7), 1'b1, make_result(ST_FULL, '0, '0));
        add_row(make_op(OP_DELETE, 31'h0765_4321, '0), 1'b1, make_result(ST_MISS, '0, '0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_op(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
            pause_sender();
        end

        // Random traffic alternates between filling and draining the table.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            calm       = (n >= CALM_FIRST && n < CALM_LAST);
            fill_phase = ((n / 150) % 2) == 0;
            roll       = $urandom_range(0, 99);
            if (roll < 5)                        opcode = OP_UNDEFINED;
            else if (roll < 30)                  opcode = OP_SEARCH;
            else if (roll < (fill_phase ? 45 : 80)) opcode = OP_DELETE;
            else                                 opcode = OP_INSERT;
            op_in.opcode  = opcode;
            op_in.key     = ($urandom_range(0, 99) < 85) ?
                            key_pool[$urandom_range(0, POOL_SIZE - 1)] : key_t'($urandom);
            op_in.payload = pay_t'($urandom);
            send_op(op_in, 1'b0, '0);
            pause_sender();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Drain the outstanding results, then allow for a late spurious transfer.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d inserts (%0d on a full table), %0d deletes, %0d searches,",
                 n_insert, n_full, n_delete, n_search);
        $display("%0d undefined opcodes and %0d misses; %0d results, %0d failures.",
                 n_undefined, n_miss, results_seen, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result side: checks each transfer and drives ready with random stalls.
    initial begin
        lpht_out_t want;
        int        holdoff_left;
        bit        holdoff_done;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $display("Unexpected result transfer: status %0d slot %0d payload %h",
                                 m_data.status, m_data.slot, m_data.found_payload);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status || m_data.slot !== want.slot ||
                        m_data.found_payload !== want.found_payload) begin
                        if (error_count < MAX_REPORTS)
                            $display("Result %0d: expected %0d/%0d/%h, got %0d/%0d/%h",
                                     results_seen, want.status, want.slot,
                                     want.found_payload, m_data.status, m_data.slot,
                                     m_data.found_payload);
                        error_count++;
                    end
                end
            end
            // One long hold-off fills the block and stalls its input.
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 35);
            end
        end
    end

endmodule
